/* rtl/core/baro_sample_average_compensate_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the barometric averaging and compensation block
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BARO_SAMPLE_AVERAGE_COMPENSATE_DEFINES_SVH
`define BARO_SAMPLE_AVERAGE_COMPENSATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BASC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("basc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BASC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("basc assertion failed");

`endif

/* rtl/core/basc_pkg.sv */
// ---------------------------------------------------------------------------
// basc_pkg
// Types and fixed constants of the barometric averaging and compensation block.
// ---------------------------------------------------------------------------
package basc_pkg;

   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int PRESS_W = 17;
   localparam int TEMP_W  = 15;

   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_C1 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_C2 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_C3 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_C4 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_C5 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_C6 = 3'd5;

   localparam int DT_W      = 26;
   localparam int MB_W      = 19;
   localparam int PROD_W    = DT_W + MB_W;
   localparam int SENS_W    = 37;
   localparam int OFF_W     = 37;
   localparam int SENS_LO_W = 18;
   localparam int LO_W      = RAW_W + SENS_LO_W;
   localparam int FULL_W    = 62;
   localparam int TEMP_SHIFT = 23;
   localparam int OFF_SHIFT  = 6;
   localparam int SENS_SHIFT = 7;
   localparam int X_SHIFT    = 21;
   localparam int P_SHIFT    = 15;
   localparam int Q_W        = FULL_W - X_SHIFT;
   localparam int X_W        = Q_W + 1;
   localparam int PW_W       = X_W - P_SHIFT;
   localparam int TW_W       = PROD_W - TEMP_SHIFT + 1;

   localparam int TEMP_BASE  = 2000;
   localparam int T_MIN      = -4000;
   localparam int T_MAX      = 8500;
   localparam int P_MAX      = 131071;
   localparam int P_OK_LIMIT = 3276800;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_type;

   typedef struct packed {
      logic [RAW_W-1:0] avg_p;
      logic [RAW_W-1:0] avg_t;
   } sample_type;

endpackage

/* rtl/core/basc_front.sv */
// ---------------------------------------------------------------------------
// basc_front
// Takes raw conversion words, keeps the two running averages and the phase,
// and queues an average pair for compensation after every pressure word.
// ---------------------------------------------------------------------------
module basc_front import basc_pkg::*; #(
   parameter int AVG_SHIFT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [RAW_W-1:0] req_conv_value,
   output logic             push,
   output sample_type       push_data,
   input  logic             q_full
);

   localparam int AW = RAW_W + 1;
   localparam logic signed [AW-1:0] AVG_BIAS = AW'((1 << AVG_SHIFT) - 1);

   logic             phase_ff, phase_in;
   logic             valid_p_ff, valid_p_in;
   logic             valid_t_ff, valid_t_in;
   logic [RAW_W-1:0] avg_p_ff, avg_p_in;
   logic [RAW_W-1:0] avg_t_ff, avg_t_in;
   logic             accept;

   function automatic logic [RAW_W-1:0] run_avg(input logic [RAW_W-1:0] avg,
                                                input logic             valid,
                                                input logic [RAW_W-1:0] x);
      logic signed [AW-1:0] diff;
      logic signed [AW-1:0] step;
      diff = $signed({1'b0, x}) - $signed({1'b0, avg});
      step = (diff + (diff[AW-1] ? AVG_BIAS : AW'(0))) >>> AVG_SHIFT;
      return valid ? avg + step[RAW_W-1:0] : x;
   endfunction

   assign req_ready = phase_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && !phase_ff;
   assign push_data = '{avg_p: avg_p_in, avg_t: avg_t_ff};

   always_comb begin
      phase_in   = phase_ff;
      valid_p_in = valid_p_ff;
      valid_t_in = valid_t_ff;
      avg_p_in   = avg_p_ff;
      avg_t_in   = avg_t_ff;
      if (accept) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            avg_t_in   = run_avg(avg_t_ff, valid_t_ff, req_conv_value);
            valid_t_in = 1'b1;
         end else begin
            avg_p_in   = run_avg(avg_p_ff, valid_p_ff, req_conv_value);
            valid_p_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         valid_p_ff <= 1'b0;
         valid_t_ff <= 1'b0;
         avg_p_ff   <= '0;
         avg_t_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         valid_p_ff <= valid_p_in;
         valid_t_ff <= valid_t_in;
         avg_p_ff   <= avg_p_in;
         avg_t_ff   <= avg_t_in;
      end
   end

endmodule

/* rtl/core/basc_queue.sv */
// ---------------------------------------------------------------------------
// basc_queue
// Two-entry queue of average pairs between the front and the compensation
// sequencer.
// ---------------------------------------------------------------------------
`include "baro_sample_average_compensate_defines.svh"

module basc_queue import basc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   input  logic       pop,
   output sample_type pop_data,
   output logic       full,
   output logic       empty
);

   sample_type        mem_ff [QDEPTH];
   sample_type        mem_in [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BASC_ASSERT_NOW(a_no_push_full, push, !full)
   `BASC_ASSERT_NOW(a_no_pop_empty, pop, !empty)

endmodule

/* rtl/core/basc_back.sv */
// ---------------------------------------------------------------------------
// basc_back
// Compensation sequencer: one shared 26 by 19 bit multiplier stepped through
// the temperature, offset, sensitivity and pressure products, with a result
// register on the output channel.
// ---------------------------------------------------------------------------
`include "baro_sample_average_compensate_defines.svh"

module basc_back import basc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  coef_type                 coef,
   input  logic                     q_empty,
   input  sample_type               q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PRESS_W-1:0]       rsp_pressure_pa,
   output logic signed [TEMP_W-1:0] rsp_temp_centideg,
   output logic                     rsp_pressure_ok
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DT   = 4'd1;
   localparam logic [3:0] ST_MT   = 4'd2;
   localparam logic [3:0] ST_MO   = 4'd3;
   localparam logic [3:0] ST_MS   = 4'd4;
   localparam logic [3:0] ST_PS   = 4'd5;
   localparam logic [3:0] ST_ML   = 4'd6;
   localparam logic [3:0] ST_MH   = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_Q    = 4'd9;
   localparam logic [3:0] ST_X    = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   logic [3:0]                state_ff, state_in;
   logic [RAW_W-1:0]          ap_ff, ap_in;
   logic [RAW_W-1:0]          at_ff, at_in;
   logic signed [DT_W-1:0]    dt_ff, dt_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [TEMP_W-1:0]  temp_ff, temp_in;
   logic signed [OFF_W-1:0]   off_ff, off_in;
   logic signed [SENS_W-1:0]  sens_ff, sens_in;
   logic [LO_W-1:0]           lo_ff, lo_in;
   logic signed [FULL_W-1:0]  full_ff, full_in;
   logic signed [Q_W-1:0]     q_ff, q_in;
   logic signed [X_W-1:0]     x_ff, x_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PRESS_W-1:0]        rsp_p_ff, rsp_p_in;
   logic signed [TEMP_W-1:0]  rsp_t_ff, rsp_t_in;
   logic                      rsp_ok_ff, rsp_ok_in;

   logic signed [DT_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [TW_W-1:0]    t_wide;
   logic signed [TEMP_W-1:0]  t_sat;
   logic signed [PROD_W-1:0]  prod_b64;
   logic signed [PROD_W-1:0]  prod_b128;
   logic signed [FULL_W-1:0]  full_b;
   logic signed [X_W-1:0]     x_b;
   logic signed [PW_W-1:0]    p_wide;
   logic [PRESS_W-1:0]        p_sat;
   logic                      out_free;

   assign mul_p    = mul_a * mul_b;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign t_wide = TW_W'($signed(prod_ff[PROD_W-1:TEMP_SHIFT])) + TW_W'(TEMP_BASE);
   always_comb begin
      if (t_wide < TW_W'(T_MIN)) begin
         t_sat = TEMP_W'(T_MIN);
      end else if (t_wide > TW_W'(T_MAX)) begin
         t_sat = TEMP_W'(T_MAX);
      end else begin
         t_sat = t_wide[TEMP_W-1:0];
      end
   end

   assign prod_b64  = prod_ff + (prod_ff[PROD_W-1] ?
                      PROD_W'((1 << OFF_SHIFT) - 1) : PROD_W'(0));
   assign prod_b128 = prod_ff + (prod_ff[PROD_W-1] ?
                      PROD_W'((1 << SENS_SHIFT) - 1) : PROD_W'(0));
   assign full_b    = full_ff + (full_ff[FULL_W-1] ?
                      FULL_W'((1 << X_SHIFT) - 1) : FULL_W'(0));
   assign x_b       = x_ff + (x_ff[X_W-1] ? X_W'((1 << P_SHIFT) - 1) : X_W'(0));
   assign p_wide    = $signed(x_b[X_W-1:P_SHIFT]);

   always_comb begin
      if (p_wide[PW_W-1]) begin
         p_sat = '0;
      end else if (p_wide > PW_W'(P_MAX)) begin
         p_sat = PRESS_W'(P_MAX);
      end else begin
         p_sat = p_wide[PRESS_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      ap_in        = ap_ff;
      at_in        = at_ff;
      dt_in        = dt_ff;
      prod_in      = prod_ff;
      temp_in      = temp_ff;
      off_in       = off_ff;
      sens_in      = sens_ff;
      lo_in        = lo_ff;
      full_in      = full_ff;
      q_in         = q_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_p_in     = rsp_p_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_ok_in    = rsp_ok_ff;
      q_pop        = 1'b0;
      mul_a        = dt_ff;
      mul_b        = $signed({3'b000, coef.c6});
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ap_in    = q_data.avg_p;
               at_in    = q_data.avg_t;
               state_in = ST_DT;
            end
         end
         ST_DT: begin
            dt_in    = $signed({2'b00, at_ff}) - $signed({2'b00, coef.c5, 8'h00});
            state_in = ST_MT;
         end
         ST_MT: begin
            prod_in  = mul_p;
            state_in = ST_MO;
         end
         ST_MO: begin
            temp_in  = t_sat;
            mul_b    = $signed({3'b000, coef.c4});
            prod_in  = mul_p;
            state_in = ST_MS;
         end
         ST_MS: begin
            off_in   = $signed(OFF_W'({coef.c2, 17'h00000}))
                       + OFF_W'($signed(prod_b64[PROD_W-1:OFF_SHIFT]));
            mul_b    = $signed({3'b000, coef.c3});
            prod_in  = mul_p;
            state_in = ST_PS;
         end
         ST_PS: begin
            sens_in  = $signed(SENS_W'({coef.c1, 16'h0000}))
                       + SENS_W'($signed(prod_b128[PROD_W-1:SENS_SHIFT]));
            state_in = ST_ML;
         end
         ST_ML: begin
            mul_a    = $signed({2'b00, ap_ff});
            mul_b    = $signed({1'b0, sens_ff[SENS_LO_W-1:0]});
            prod_in  = mul_p;
            state_in = ST_MH;
         end
         ST_MH: begin
            lo_in    = prod_ff[LO_W-1:0];
            mul_a    = $signed({2'b00, ap_ff});
            mul_b    = sens_ff[SENS_W-1:SENS_LO_W];
            prod_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            full_in  = (FULL_W'(prod_ff) <<< SENS_LO_W) + $signed(FULL_W'(lo_ff));
            state_in = ST_Q;
         end
         ST_Q: begin
            q_in     = $signed(full_b[FULL_W-1:X_SHIFT]);
            state_in = ST_X;
         end
         ST_X: begin
            x_in     = X_W'(q_ff) - X_W'(off_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_p_in     = p_sat;
               rsp_t_in     = temp_ff;
               rsp_ok_in    = (x_ff >= X_W'(P_OK_LIMIT));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ap_ff     <= ap_in;
      at_ff     <= at_in;
      dt_ff     <= dt_in;
      prod_ff   <= prod_in;
      temp_ff   <= temp_in;
      off_ff    <= off_in;
      sens_ff   <= sens_in;
      lo_ff     <= lo_in;
      full_ff   <= full_in;
      q_ff      <= q_in;
      x_ff      <= x_in;
      rsp_p_ff  <= rsp_p_in;
      rsp_t_ff  <= rsp_t_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressure_pa   = rsp_p_ff;
   assign rsp_temp_centideg = rsp_t_ff;
   assign rsp_pressure_ok   = rsp_ok_ff;

   `BASC_ASSERT_NOW(a_pop_only_idle, q_pop, state_ff == ST_IDLE)
   `BASC_ASSERT_NEXT(a_start_seq, state_ff == ST_IDLE && !q_empty, state_ff == ST_DT)
   `BASC_ASSERT_NEXT(a_fin_waits, state_ff == ST_FIN && !out_free,
                     state_ff == ST_FIN && rsp_valid_ff)

endmodule

/* rtl/core/baro_sample_average_compensate.sv */
// ---------------------------------------------------------------------------
// baro_sample_average_compensate
// Running averages of raw pressure and temperature words with first-order
// compensation, calibration words on an APB-style register port.
// ---------------------------------------------------------------------------
// A temperature word is taken and gives no result.
// A pressure word gives its result once the shared multiplier sequencer is
// through its states; it ends one word before it takes the next, which sets
// the sustained rate, and a two-entry queue lets the input run ahead of it.
// Synchronous reset clears the phase, both averages, the calibration words,
// the queue and the output valid; there is no clearing pass.
module baro_sample_average_compensate import basc_pkg::*; #(
   parameter int AVG_SHIFT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RAW_W-1:0]         req_conv_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PRESS_W-1:0]       rsp_pressure_pa,
   output logic signed [TEMP_W-1:0] rsp_temp_centideg,
   output logic                     rsp_pressure_ok,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   output logic [CSR_DW-1:0]        csr_prdata,
   output logic                     csr_pready
);

   coef_type               coef_ff, coef_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic [COEF_W-1:0]      rd_word;
   logic                   wr_en;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_empty;
   sample_type             push_data;
   sample_type             pop_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CSR_DW'(rd_word);

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_C1:  coef_in.c1 = csr_pwdata[COEF_W-1:0];
            REG_C2:  coef_in.c2 = csr_pwdata[COEF_W-1:0];
            REG_C3:  coef_in.c3 = csr_pwdata[COEF_W-1:0];
            REG_C4:  coef_in.c4 = csr_pwdata[COEF_W-1:0];
            REG_C5:  coef_in.c5 = csr_pwdata[COEF_W-1:0];
            REG_C6:  coef_in.c6 = csr_pwdata[COEF_W-1:0];
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_C1:  rd_word = coef_ff.c1;
         REG_C2:  rd_word = coef_ff.c2;
         REG_C3:  rd_word = coef_ff.c3;
         REG_C4:  rd_word = coef_ff.c4;
         REG_C5:  rd_word = coef_ff.c5;
         REG_C6:  rd_word = coef_ff.c6;
         default: rd_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   basc_front #(
      .AVG_SHIFT (AVG_SHIFT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_conv_value (req_conv_value),
      .push           (push),
      .push_data      (push_data),
      .q_full         (q_full)
   );

   basc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   basc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .coef              (coef_ff),
      .q_empty           (q_empty),
      .q_data            (pop_data),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pressure_pa   (rsp_pressure_pa),
      .rsp_temp_centideg (rsp_temp_centideg),
      .rsp_pressure_ok   (rsp_pressure_ok)
   );

endmodule

/* tb/sv/baro_sample_average_compensate_tb.sv */
// ---------------------------------------------------------------------------
// Testbench for baro_sample_average_compensate
// Sends raw conversion words that alternate between pressure and temperature,
// writes the calibration words over the register port between phases, and
// compares every compensated reading with a running prediction of the
// averages and the first-order compensation.
// ---------------------------------------------------------------------------
module baro_sample_average_compensate_tb import basc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AVG_SHIFT    = 4;
   localparam int CLK_PERIOD   = 10;
   localparam int SETTLE_TAIL  = 32;
   localparam int LONG_HOLD    = 300;
   localparam int LIMIT_CYCLES = 500000;
   localparam int MAX_REPORTS  = 10;

   localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam logic [COEF_W-1:0] TYP_C1 = 16'd40127;
   localparam logic [COEF_W-1:0] TYP_C2 = 16'd36924;
   localparam logic [COEF_W-1:0] TYP_C3 = 16'd23317;
   localparam logic [COEF_W-1:0] TYP_C4 = 16'd23282;
   localparam logic [COEF_W-1:0] TYP_C5 = 16'd33464;
   localparam logic [COEF_W-1:0] TYP_C6 = 16'd28312;
   localparam logic [RAW_W-1:0]  RAW_P_TYP = 24'd9085466;
   localparam logic [RAW_W-1:0]  RAW_T_TYP = 24'd8569150;
   localparam logic [RAW_W-1:0]  RAW_MAX   = {RAW_W{1'b1}};
   localparam logic [COEF_W-1:0] COEF_MAX  = {COEF_W{1'b1}};

   localparam longint TEMP_DIV = 64'sd1 << TEMP_SHIFT;
   localparam longint X_DIV    = 64'sd1 << X_SHIFT;

   typedef struct packed {
      logic [PRESS_W-1:0]        pressure_pa;
      logic signed [TEMP_W-1:0]  temp_centideg;
      logic                      pressure_ok;
   } reading_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [RAW_W-1:0]         req_conv_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [PRESS_W-1:0]       rsp_pressure_pa;
   logic signed [TEMP_W-1:0] rsp_temp_centideg;
   logic                     rsp_pressure_ok;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_AW-1:0]        csr_paddr;
   logic [CSR_DW-1:0]        csr_pwdata;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   logic [COEF_W-1:0] cal_word [6];
   logic              phase_temp = 1'b0;
   logic              press_seen = 1'b0;
   logic              temp_seen  = 1'b0;
   logic [RAW_W-1:0]  avg_press  = '0;
   logic [RAW_W-1:0]  avg_temp   = '0;
   reading_type       pending_readings [$];

   int   error_count   = 0;
   logic send_steady   = 1'b0;
   logic recv_steady   = 1'b0;
   logic hold_request  = 1'b0;

   baro_sample_average_compensate #(
      .AVG_SHIFT(AVG_SHIFT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_conv_value   (req_conv_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pressure_pa  (rsp_pressure_pa),
      .rsp_temp_centideg(rsp_temp_centideg),
      .rsp_pressure_ok  (rsp_pressure_ok),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic int idle_len(input logic steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [RAW_W-1:0] smoothed(input logic [RAW_W-1:0] avg,
                                                 input logic seen,
                                                 input logic [RAW_W-1:0] x);
      longint step;
      if (!seen) return x;
      step = (longint'(x) - longint'(avg)) / (longint'(1) << AVG_SHIFT);
      return RAW_W'(longint'(avg) + step);
   endfunction

   function automatic reading_type compensated_reading();
      longint c1, c2, c3, c4, c5, c6;
      longint dt, tprod, temp, off, sens, x, p;
      reading_type r;
      c1 = longint'(cal_word[REG_C1]);
      c2 = longint'(cal_word[REG_C2]);
      c3 = longint'(cal_word[REG_C3]);
      c4 = longint'(cal_word[REG_C4]);
      c5 = longint'(cal_word[REG_C5]);
      c6 = longint'(cal_word[REG_C6]);
      dt    = longint'(avg_temp) - (c5 << 8);
      tprod = dt * c6;
      if (tprod >= 0) begin
         temp = TEMP_BASE + tprod / TEMP_DIV;
      end else begin
         temp = TEMP_BASE - (-tprod + TEMP_DIV - 1) / TEMP_DIV;
      end
      off  = (c2 << 17) + (c4 * dt) / (longint'(1) << OFF_SHIFT);
      sens = (c1 << 16) + (c3 * dt) / (longint'(1) << SENS_SHIFT);
      x    = (longint'(avg_press) * sens) / X_DIV - off;
      p    = x / (longint'(1) << P_SHIFT);
      r.pressure_ok = (x >= longint'(P_OK_LIMIT));
      if (p < 0) p = 0;
      if (p > P_MAX) p = P_MAX;
      if (temp < T_MIN) temp = T_MIN;
      if (temp > T_MAX) temp = T_MAX;
      r.pressure_pa   = p[PRESS_W-1:0];
      r.temp_centideg = temp[TEMP_W-1:0];
      return r;
   endfunction

   function automatic void take_conversion(input logic [RAW_W-1:0] x);
      if (phase_temp) begin
         avg_temp   = smoothed(avg_temp, temp_seen, x);
         temp_seen  = 1'b1;
         phase_temp = 1'b0;
      end else begin
         avg_press  = smoothed(avg_press, press_seen, x);
         press_seen = 1'b1;
         phase_temp = 1'b1;
         pending_readings.push_back(compensated_reading());
      end
   endfunction

   function automatic void note_mismatch(input string field, input longint want,
                                         input longint got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
      end
   endfunction

   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            note_mismatch("unexpected reading, pressure_pa", -1, rsp_pressure_pa);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_pressure_pa !== want.pressure_pa) begin
               note_mismatch("pressure_pa", want.pressure_pa, rsp_pressure_pa);
            end
            if (rsp_temp_centideg !== want.temp_centideg) begin
               note_mismatch("temp_centideg", longint'(want.temp_centideg),
                             longint'(rsp_temp_centideg));
            end
            if (rsp_pressure_ok !== want.pressure_ok) begin
               note_mismatch("pressure_ok", want.pressure_ok, rsp_pressure_ok);
            end
         end
      end
   end

   initial begin : result_stall
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end else if (stall == 0) begin
            stall = idle_len(recv_steady);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_conv(input logic [RAW_W-1:0] value);
      int gap;
      gap = idle_len(send_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_conv_value <= value;
      do @(posedge clock); while (!req_ready);
      take_conversion(value);
   endtask

   task automatic send_next(input logic [RAW_W-1:0] press_raw,
                            input logic [RAW_W-1:0] temp_raw);
      send_conv(phase_temp ? temp_raw : press_raw);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx <= REG_C6) cal_word[idx] = data[COEF_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_cal(input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                            input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
                            input logic [COEF_W-1:0] c5, input logic [COEF_W-1:0] c6);
      csr_write(REG_C1, {16'($urandom()), c1});
      csr_write(REG_C2, {16'($urandom()), c2});
      csr_write(REG_C3, {16'($urandom()), c3});
      csr_write(REG_C4, {16'($urandom()), c4});
      csr_write(REG_C5, {16'($urandom()), c5});
      csr_write(REG_C6, {16'($urandom()), c6});
   endtask

   function automatic logic [COEF_W-1:0] rand_coef(input logic [COEF_W-1:0] typical);
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return COEF_MAX;
      if (r < 4) return COEF_W'($urandom());
      return typical ^ COEF_W'($urandom_range(0, 2047));
   endfunction

   function automatic logic [RAW_W-1:0] rand_raw(input logic [RAW_W-1:0] typical);
      int r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r == 1) return RAW_MAX;
      if (r < 5) return RAW_W'($urandom());
      return typical ^ RAW_W'($urandom_range(0, 65535));
   endfunction

   // Coefficients are all zero here, and the first pressure word arrives before
   // any temperature word; a raw zero must still count as the first sample.
   task automatic test_first_samples();
      send_conv('0);
      send_conv('0);
      send_conv(RAW_MAX);
      send_conv(RAW_MAX);
      settle();
   endtask

   task automatic test_register_extremes();
      write_cal(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      csr_write(REG_SPARE_LO, $urandom());
      csr_write(REG_SPARE_HI, $urandom());
      repeat (4) send_conv(RAW_W'($urandom()));
      settle();
   endtask

   task automatic test_typical_calibration();
      write_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
      repeat (4) send_next(RAW_P_TYP, RAW_T_TYP);
      settle();
   endtask

   task automatic test_saturation();
      write_cal(COEF_MAX, '0, '0, '0, '0, COEF_MAX);
      repeat (4) send_conv(RAW_MAX);
      settle();
      write_cal('0, COEF_MAX, '0, '0, COEF_MAX, COEF_MAX);
      repeat (4) send_conv('0);
      settle();
   endtask

   // The gain is chosen from the current pressure average so that the reading
   // lands at or just above 60 Pa and 100 Pa, with the average unchanged.
   task automatic test_low_pressure();
      longint target [2];
      longint gain;
      target[0] = 60;
      target[1] = 100;
      for (int i = 0; i < 2; i++) begin
         gain = ((target[i] << 20) + longint'(avg_press) - 1) / longint'(avg_press);
         if (gain > COEF_MAX) gain = COEF_MAX;
         write_cal(gain[COEF_W-1:0], '0, '0, '0, TYP_C5, TYP_C6);
         repeat (2) send_next(avg_press, RAW_T_TYP);
         settle();
      end
   endtask

   task automatic test_output_stall();
      hold_request = 1'b1;
      do @(posedge clock); while (hold_request);
      send_steady = 1'b1;
      repeat (24) send_next(rand_raw(RAW_P_TYP), rand_raw(RAW_T_TYP));
      send_steady = 1'b0;
      settle();
   endtask

   task automatic test_random_sequences();
      for (int ph = 0; ph < 10; ph++) begin
         write_cal(rand_coef(TYP_C1), rand_coef(TYP_C2), rand_coef(TYP_C3),
                   rand_coef(TYP_C4), rand_coef(TYP_C5), rand_coef(TYP_C6));
         send_steady = ($urandom_range(3) == 0);
         recv_steady = ($urandom_range(3) == 0);
         repeat (50) send_next(rand_raw(RAW_P_TYP), rand_raw(RAW_T_TYP));
         settle();
      end
      send_steady = 1'b0;
      recv_steady = 1'b0;
   endtask

   initial begin : stimulus
      foreach (cal_word[i]) cal_word[i] = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_conv_value <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_first_samples();
      test_register_extremes();
      test_typical_calibration();
      test_saturation();
      test_low_pressure();
      test_output_stall();
      test_random_sequences();
      settle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule

/* baro_sample_average_compensate.f */
+incdir+rtl/core
rtl/core/basc_pkg.sv
rtl/core/basc_front.sv
rtl/core/basc_queue.sv
rtl/core/basc_back.sv
rtl/core/baro_sample_average_compensate.sv
tb/sv/baro_sample_average_compensate_tb.sv
